>>> rtl/button_press_qualifier_macros.svh
// assertion macros for the button press qualifier
// used by the top level, no other dependencies
`ifndef BUTTON_PRESS_QUALIFIER_MACROS_SVH
`define BUTTON_PRESS_QUALIFIER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bpq_pkg.sv
// shared types, register indexes and reset values of the button press qualifier
// no dependencies
package bpq_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_W         = 32;
  localparam int DEB_W         = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_ENABLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD_MS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_ENABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_HOLD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 3'd6;

  localparam logic             RST_ACTIVE_LOW  = 1'b1;
  localparam logic [DEB_W-1:0] RST_DEBOUNCE_MS = 16'd50;

  typedef struct packed {
    logic             active_low;
    logic [DEB_W-1:0] debounce_ms;
    logic             long_enable;
    logic [NOW_W-1:0] long_hold_ms;
    logic             double_enable;
    logic [NOW_W-1:0] double_hold_ms;
    logic [NOW_W-1:0] double_window_ms;
  } bpq_cfg_t;

  typedef struct packed {
    logic press_pulse;
    logic long_pulse;
    logic double_long_pulse;
    logic held;
  } bpq_res_t;

endpackage

>>> rtl/button_press_qualifier.sv
// button press qualifier top level: input register, poll logic, result register
// depends on bpq_pkg, bpq_cfg, bpq_core and button_press_qualifier_macros.svh
//
// usage
// - input channel in_valid/in_stall carries one poll request: in_pin_level, in_now_ms
// - result channel out_valid/out_stall returns one result request per poll:
//   out_press_pulse, out_long_pulse, out_double_long_pulse, out_held
// - configuration is a write port (cfg_wr_en, cfg_index, cfg_wdata), written while idle;
//   indexes beyond the last register are ignored
// - a poll waits in the input register, and its result is captured in the result register when it advances
// - throughput: one poll per cycle while out_stall is low; the poll logic between the
//   input register and the result register is combinational and updates the button state as a poll advances
// - reset (rst_n low, synchronous) clears both stages, the button state and loads
//   register defaults (active low polarity, 50 ms debounce, detectors off)
// - a stalled result holds; the input register keeps filling until both stages are
//   full, then in_stall follows out_stall
`include "button_press_qualifier_macros.svh"

module button_press_qualifier #(
  parameter int TIME_BITS = bpq_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_pin_level,
  input  logic [bpq_pkg::NOW_W-1:0]      in_now_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_press_pulse,
  output logic                           out_long_pulse,
  output logic                           out_double_long_pulse,
  output logic                           out_held,
  input  logic                           cfg_wr_en,
  input  logic [bpq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bpq_pkg::*;

  bpq_cfg_t         cfg;
  bpq_res_t         res;
  logic             stage_vld_r;
  logic             stage_level_r;
  logic [NOW_W-1:0] stage_now_r;
  logic             out_vld_r;
  bpq_res_t         out_res_r;
  logic             advance;
  logic             in_take;

  assign advance  = stage_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = stage_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  bpq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bpq_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .pin_level (stage_level_r),
    .now_ms    (stage_now_r),
    .cfg       (cfg),
    .res       (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else if (in_take) begin
      stage_vld_r <= 1'b1;
    end else if (advance) begin
      stage_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_level_r <= in_pin_level;
      stage_now_r   <= in_now_ms;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_press_pulse       = out_res_r.press_pulse;
  assign out_long_pulse        = out_res_r.long_pulse;
  assign out_double_long_pulse = out_res_r.double_long_pulse;
  assign out_held              = out_res_r.held;

  `BPQ_ASSERT_NOW(a_press_held, clk, rst_n, out_vld_r && out_res_r.press_pulse, out_res_r.held, "press pulse without held")
  `BPQ_ASSERT_NOW(a_long_held, clk, rst_n, out_vld_r && out_res_r.long_pulse, out_res_r.held, "long pulse without held")
  `BPQ_ASSERT_NOW(a_double_held, clk, rst_n, out_vld_r && out_res_r.double_long_pulse, out_res_r.held, "double long pulse without held")
  `BPQ_ASSERT_NEXT(a_stall_holds, clk, rst_n, in_stall, stage_vld_r && out_vld_r, "stall with an empty stage")

endmodule

>>> rtl/bpq_cfg.sv
// configuration register file of the button press qualifier
// depends on bpq_pkg
module bpq_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [bpq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output bpq_pkg::bpq_cfg_t                  cfg
);
  import bpq_pkg::*;

  bpq_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_low       <= RST_ACTIVE_LOW;
      cfg_r.debounce_ms      <= RST_DEBOUNCE_MS;
      cfg_r.long_enable      <= 1'b0;
      cfg_r.long_hold_ms     <= '0;
      cfg_r.double_enable    <= 1'b0;
      cfg_r.double_hold_ms   <= '0;
      cfg_r.double_window_ms <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ACTIVE_LOW:    cfg_r.active_low       <= cfg_wdata[0];
        REG_DEBOUNCE_MS:   cfg_r.debounce_ms      <= cfg_wdata[DEB_W-1:0];
        REG_LONG_ENABLE:   cfg_r.long_enable      <= cfg_wdata[0];
        REG_LONG_HOLD_MS:  cfg_r.long_hold_ms     <= cfg_wdata[NOW_W-1:0];
        REG_DOUBLE_ENABLE: cfg_r.double_enable    <= cfg_wdata[0];
        REG_DOUBLE_HOLD:   cfg_r.double_hold_ms   <= cfg_wdata[NOW_W-1:0];
        REG_DOUBLE_WINDOW: cfg_r.double_window_ms <= cfg_wdata[NOW_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/bpq_core.sv
// per-poll debounce, long-press and double-long-press logic with its state
// depends on bpq_pkg
module bpq_core #(
  parameter int TIME_BITS = bpq_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        pin_level,
  input  logic [bpq_pkg::NOW_W-1:0]   now_ms,
  input  bpq_pkg::bpq_cfg_t           cfg,
  output bpq_pkg::bpq_res_t           res
);
  import bpq_pkg::*;

  localparam int TW = TIME_BITS;
  localparam int CW = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

  typedef enum logic [1:0] {DS_IDLE, DS_FIRST, DS_WAIT, DS_SECOND} dual_state_t;

  logic          prev_r, prev_nxt;
  logic [TW-1:0] change_r, change_nxt;
  logic          latched_r, latched_nxt;
  logic [TW-1:0] hold_r, hold_nxt;
  logic          long_done_r, long_done_nxt;
  dual_state_t   ds_r, ds_nxt;
  logic [TW-1:0] dstart_r, dstart_nxt;
  logic [TW-1:0] drel_r, drel_nxt;
  logic          fhm_r, fhm_nxt;

  logic [CW-1:0] now_ext;
  logic [TW-1:0] now_t;
  logic          pressed;
  logic [TW-1:0] el_chg, el_hold, el_dual, el_rel;
  logic          deb_ok;
  logic          p_pulse, l_pulse, d_pulse;

  assign now_ext = CW'(now_ms);
  assign now_t   = now_ext[TW-1:0];

  always_comb begin
    pressed       = cfg.active_low ? ~pin_level : pin_level;
    prev_nxt      = pressed;
    change_nxt    = change_r;
    hold_nxt      = hold_r;
    long_done_nxt = long_done_r;
    latched_nxt   = latched_r;
    ds_nxt        = ds_r;
    dstart_nxt    = dstart_r;
    drel_nxt      = drel_r;
    fhm_nxt       = fhm_r;
    p_pulse       = 1'b0;
    l_pulse       = 1'b0;
    d_pulse       = 1'b0;

    // raw change of the pressed value
    if (pressed != prev_r) begin
      change_nxt    = now_t;
      hold_nxt      = pressed ? now_t : '0;
      long_done_nxt = 1'b0;
    end

    el_chg = now_t - change_nxt;
    deb_ok = CW'(el_chg) > CW'(cfg.debounce_ms);

    if (pressed && !latched_r && deb_ok) begin
      latched_nxt = 1'b1;
      p_pulse     = 1'b1;
      if (cfg.double_enable) begin
        if (ds_r == DS_IDLE) begin
          ds_nxt     = DS_FIRST;
          dstart_nxt = now_t;
          fhm_nxt    = 1'b0;
        end else if (ds_r == DS_WAIT) begin
          ds_nxt     = DS_SECOND;
          dstart_nxt = now_t;
        end else begin
          ds_nxt = DS_IDLE;
        end
      end
    end else if (!pressed && latched_r && deb_ok) begin
      latched_nxt = 1'b0;
      if (cfg.double_enable) begin
        if (ds_r == DS_FIRST) begin
          if (fhm_r) begin
            ds_nxt   = DS_WAIT;
            drel_nxt = now_t;
          end else begin
            ds_nxt = DS_IDLE;
          end
        end else if (ds_r == DS_SECOND) begin
          ds_nxt = DS_IDLE;
        end
      end
    end

    el_hold = now_t - hold_nxt;
    if (pressed && latched_nxt && !long_done_nxt && cfg.long_enable &&
        (cfg.long_hold_ms != '0) && (CW'(el_hold) >= CW'(cfg.long_hold_ms))) begin
      long_done_nxt = 1'b1;
      l_pulse       = 1'b1;
    end

    el_dual = now_t - dstart_nxt;
    el_rel  = now_t - drel_nxt;
    if (cfg.double_enable && (cfg.double_hold_ms != '0)) begin
      if (latched_nxt) begin
        if (ds_nxt == DS_FIRST && !fhm_nxt &&
            CW'(el_dual) >= CW'(cfg.double_hold_ms)) begin
          fhm_nxt = 1'b1;
        end
        if (ds_nxt == DS_SECOND && CW'(el_dual) >= CW'(cfg.double_hold_ms)) begin
          ds_nxt  = DS_IDLE;
          d_pulse = 1'b1;
        end
      end else if (ds_nxt == DS_WAIT && (cfg.double_window_ms != '0) &&
                   CW'(el_rel) >= CW'(cfg.double_window_ms)) begin
        ds_nxt = DS_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= 1'b0;
      change_r    <= '0;
      latched_r   <= 1'b0;
      hold_r      <= '0;
      long_done_r <= 1'b0;
      ds_r        <= DS_IDLE;
      dstart_r    <= '0;
      drel_r      <= '0;
      fhm_r       <= 1'b0;
    end else if (step) begin
      prev_r      <= prev_nxt;
      change_r    <= change_nxt;
      latched_r   <= latched_nxt;
      hold_r      <= hold_nxt;
      long_done_r <= long_done_nxt;
      ds_r        <= ds_nxt;
      dstart_r    <= dstart_nxt;
      drel_r      <= drel_nxt;
      fhm_r       <= fhm_nxt;
    end
  end

  assign res.press_pulse       = p_pulse;
  assign res.long_pulse        = l_pulse;
  assign res.double_long_pulse = d_pulse;
  assign res.held              = latched_nxt;

endmodule
